[sv/dfa_pkg.sv]
package dfa_pkg;

    localparam int STATE_DEPTH        = 16;
    localparam int STATE_RECORD_BYTES = 16;
    localparam int RECORD_ALIGN       = 4;

    localparam int ADDR_W = 32;
    localparam int SUM_W  = ADDR_W + 2;
    localparam int IDX_W  = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STATE_DEPTH + 1);
    localparam int CFG_W  = 2;

    typedef enum logic [2:0] {
        FUNC_INIT    = 3'd0,
        FUNC_ALLOC   = 3'd1,
        FUNC_FREE    = 3'd2,
        FUNC_RECORD  = 3'd3,
        FUNC_RESTORE = 3'd4,
        FUNC_RESIZE  = 3'd5,
        FUNC_ADJUST  = 3'd6,
        FUNC_QUERY   = 3'd7
    } func_t;

    localparam logic [CFG_W-1:0] CFG_REGION_START = 2'd0;
    localparam logic [CFG_W-1:0] CFG_REGION_LIMIT = 2'd1;
    localparam logic [CFG_W-1:0] CFG_HEAP_BASE    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP1,
        ST_STEP2,
        ST_SEARCH,
        ST_DONE
    } seq_state_t;

    // shared add/subtract unit: res = (op_a +/- op_b) & mask, le = !neg && res <= cmp
    typedef struct packed {
        logic [SUM_W-1:0]  op_a;
        logic [SUM_W-1:0]  op_b;
        logic              sub;
        logic [SUM_W-1:0]  mask;
        logic [ADDR_W-1:0] cmp;
    } alu_req_t;

    typedef struct packed {
        logic [SUM_W-1:0] res;
        logic             neg;
        logic             le;
    } alu_rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] head;
        logic [ADDR_W-1:0] tail;
    } frame_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        frame_t           wr_data;
        logic [IDX_W-1:0] rd_idx;
    } stk_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] value;
        logic              ok;
    } result_t;

endpackage

[sv/double_ended_frame_allocator.sv]
// Double-ended frame allocator: head grows up from region_start, tail grows
// down from the region end, plus a stack of saved head/tail states.
// Input channel s_*: one request per item (func selects the operation).
// Result channel m_*: one result per request, value and ok.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write region_start (0),
// region_limit (1) and heap_base (2); write only while the block is idle.
// Sequencer paths from the accepted request to the result in ST_DONE:
// free, refused record and restore on an empty stack go straight to
// ST_DONE; init, adjust and a downward alloc larger than the tail pass
// through ST_STEP1; alloc, record, resize and query pass through ST_STEP1
// and ST_STEP2 (two passes through the shared add/subtract unit); restore
// walks the saved states in ST_SEARCH (one stack memory read per cycle, up to 16).
// s_ready is high only while the sequencer is idle, so the next request
// can be taken in the cycle after a result moves to the output register.
// The output register lets one finished result wait while the next request
// is worked on; if the receiver stalls longer, the sequencer holds.
// Reset clears head, tail, region end, stack count and the configuration
// registers; the stack memory itself is not cleared.
module double_ended_frame_allocator (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [dfa_pkg::CFG_W-1:0]  cfg_addr,
    input  logic [dfa_pkg::ADDR_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 s_func,
    input  logic [dfa_pkg::ADDR_W-1:0] s_alloc_size,
    input  logic [3:0]                 s_align_shift,
    input  logic                       s_from_tail,
    input  logic [1:0]                 s_free_mode,
    input  logic [dfa_pkg::ADDR_W-1:0] s_tag,
    input  logic [dfa_pkg::ADDR_W-1:0] s_block_address,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [dfa_pkg::ADDR_W-1:0] m_value,
    output logic                       m_ok
);
    import dfa_pkg::*;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    stk_req_t stk_req;
    frame_t   rd_data;
    result_t  res;
    logic     res_valid;
    logic     res_ready;
    logic     load;

    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_value_reg;
    logic              m_ok_reg;

    dfa_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    dfa_stack u_stack (
        .aclk    (aclk),
        .req     (stk_req),
        .rd_data (rd_data)
    );

    dfa_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_alloc_size    (s_alloc_size),
        .s_align_shift   (s_align_shift),
        .s_from_tail     (s_from_tail),
        .s_free_mode     (s_free_mode),
        .s_tag           (s_tag),
        .s_block_address (s_block_address),
        .alu_req         (alu_req),
        .alu_rsp         (alu_rsp),
        .stk_req         (stk_req),
        .rd_data         (rd_data),
        .res_valid       (res_valid),
        .res             (res),
        .res_ready       (res_ready)
    );

    assign res_ready = !m_valid_reg || m_ready;
    assign load      = res_valid && res_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_value_reg <= res.value;
            m_ok_reg    <= res.ok;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_ok    = m_ok_reg;

endmodule

[sv/dfa_alu.sv]
module dfa_alu (
    input  dfa_pkg::alu_req_t req,
    output dfa_pkg::alu_rsp_t rsp
);
    import dfa_pkg::*;

    logic [SUM_W:0] raw;
    logic [SUM_W:0] opb_ext;
    logic [SUM_W-1:0] masked;
    logic neg;

    always_comb begin
        opb_ext = req.sub ? ~{1'b0, req.op_b} : {1'b0, req.op_b};
        raw     = {1'b0, req.op_a} + opb_ext + {{SUM_W{1'b0}}, req.sub};
        neg     = req.sub & raw[SUM_W];
        masked  = raw[SUM_W-1:0] & req.mask;
    end

    assign rsp.res = masked;
    assign rsp.neg = neg;
    assign rsp.le  = !neg && (masked <= {{(SUM_W - ADDR_W){1'b0}}, req.cmp});

endmodule

[sv/dfa_stack.sv]
module dfa_stack (
    input  logic              aclk,
    input  dfa_pkg::stk_req_t req,
    output dfa_pkg::frame_t   rd_data
);
    import dfa_pkg::*;

    frame_t mem [STATE_DEPTH];
    frame_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_idx] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_idx];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/dfa_seq.sv]
module dfa_seq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [dfa_pkg::CFG_W-1:0]         cfg_addr,
    input  logic [dfa_pkg::ADDR_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_func,
    input  logic [dfa_pkg::ADDR_W-1:0]        s_alloc_size,
    input  logic [3:0]                        s_align_shift,
    input  logic                              s_from_tail,
    input  logic [1:0]                        s_free_mode,
    input  logic [dfa_pkg::ADDR_W-1:0]        s_tag,
    input  logic [dfa_pkg::ADDR_W-1:0]        s_block_address,
    output dfa_pkg::alu_req_t                 alu_req,
    input  dfa_pkg::alu_rsp_t                 alu_rsp,
    output dfa_pkg::stk_req_t                 stk_req,
    input  dfa_pkg::frame_t                   rd_data,
    output logic                              res_valid,
    output dfa_pkg::result_t                  res,
    input  logic                              res_ready
);
    import dfa_pkg::*;

    seq_state_t state_reg, state_next;

    logic [ADDR_W-1:0] start_reg, limit_reg, base_reg;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    func_t             func_reg, func_next;
    logic [ADDR_W-1:0] size_reg, size_next;
    logic [3:0]        shift_reg, shift_next;
    logic              down_reg, down_next;
    logic [ADDR_W-1:0] tag_reg, tag_next;
    logic [ADDR_W-1:0] baddr_reg, baddr_next;
    logic [SUM_W-1:0]  tmp_reg, tmp_next;
    logic [ADDR_W-1:0] value_reg, value_next;
    logic              ok_reg, ok_next;

    logic              accept;
    logic              match;
    logic              stack_full;
    logic [SUM_W-1:0]  align_m1;
    logic [SUM_W-1:0]  align_mask;
    logic [SUM_W-1:0]  rec_mask;
    logic [CNT_W-1:0]  idx_m1;
    logic [CNT_W-1:0]  idx_m2;
    logic [CNT_W-1:0]  count_m1;

    assign accept     = s_valid && (state_reg == ST_IDLE);
    assign s_ready    = (state_reg == ST_IDLE);
    assign match      = (tag_reg == '0) || (rd_data.tag == tag_reg);
    assign stack_full = (count_reg == CNT_W'(STATE_DEPTH));
    assign align_m1   = (SUM_W'(1) << shift_reg) - SUM_W'(1);
    assign align_mask = ~align_m1;
    assign rec_mask   = ~SUM_W'(RECORD_ALIGN - 1);
    assign idx_m1     = idx_reg - CNT_W'(1);
    assign idx_m2     = idx_reg - CNT_W'(2);
    assign count_m1   = count_reg - CNT_W'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (func_t'(s_func))
                        FUNC_FREE:    state_next = ST_DONE;
                        FUNC_RECORD:  state_next = stack_full ? ST_DONE : ST_STEP1;
                        FUNC_RESTORE: state_next = (count_reg == '0) ? ST_DONE : ST_SEARCH;
                        default:      state_next = ST_STEP1;
                    endcase
                end
            end
            ST_STEP1: begin
                case (func_reg)
                    FUNC_INIT, FUNC_ADJUST: state_next = ST_DONE;
                    FUNC_ALLOC: state_next = (down_reg && alu_rsp.neg) ? ST_DONE : ST_STEP2;
                    default:    state_next = ST_STEP2;
                endcase
            end
            ST_STEP2:  state_next = ST_DONE;
            ST_SEARCH: state_next = (match || idx_reg == CNT_W'(1)) ? ST_DONE : ST_SEARCH;
            ST_DONE:   state_next = res_ready ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // shared unit operands and stack port
    always_comb begin
        alu_req.op_a = '0;
        alu_req.op_b = '0;
        alu_req.sub  = 1'b0;
        alu_req.mask = '1;
        alu_req.cmp  = tail_reg;
        case (state_reg)
            ST_STEP1: begin
                case (func_reg)
                    FUNC_INIT: begin
                        alu_req.op_a = SUM_W'(limit_reg);
                        alu_req.op_b = SUM_W'(start_reg);
                        alu_req.sub  = 1'b1;
                    end
                    FUNC_ALLOC: begin
                        if (down_reg) begin
                            alu_req.op_a = SUM_W'(tail_reg);
                            alu_req.op_b = SUM_W'(size_reg);
                            alu_req.sub  = 1'b1;
                        end else begin
                            alu_req.op_a = SUM_W'(head_reg);
                            alu_req.op_b = align_m1;
                        end
                        alu_req.mask = align_mask;
                    end
                    FUNC_RECORD: begin
                        alu_req.op_a = SUM_W'(head_reg);
                        alu_req.op_b = SUM_W'(RECORD_ALIGN - 1);
                        alu_req.mask = rec_mask;
                    end
                    FUNC_RESIZE: begin
                        alu_req.op_a = SUM_W'(baddr_reg);
                        alu_req.op_b = SUM_W'(size_reg);
                    end
                    FUNC_ADJUST: begin
                        alu_req.op_a = SUM_W'(head_reg);
                        alu_req.op_b = SUM_W'(base_reg);
                        alu_req.sub  = 1'b1;
                    end
                    FUNC_QUERY: begin
                        alu_req.op_a = SUM_W'(head_reg);
                        alu_req.op_b = align_m1;
                        alu_req.mask = align_mask;
                    end
                    default: ;
                endcase
            end
            ST_STEP2: begin
                case (func_reg)
                    FUNC_ALLOC: begin
                        alu_req.op_a = tmp_reg;
                        if (down_reg) begin
                            alu_req.op_b = SUM_W'(head_reg);
                            alu_req.sub  = 1'b1;
                        end else begin
                            alu_req.op_b = SUM_W'(size_reg);
                        end
                    end
                    FUNC_RECORD: begin
                        alu_req.op_a = tmp_reg;
                        alu_req.op_b = SUM_W'(STATE_RECORD_BYTES);
                    end
                    FUNC_RESIZE: begin
                        alu_req.op_a = tmp_reg;
                        alu_req.op_b = SUM_W'(RECORD_ALIGN - 1);
                        alu_req.mask = rec_mask;
                    end
                    FUNC_QUERY: begin
                        alu_req.op_a = SUM_W'(tail_reg);
                        alu_req.op_b = tmp_reg;
                        alu_req.sub  = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        stk_req.wr_en   = (state_reg == ST_STEP2) && (func_reg == FUNC_RECORD) && alu_rsp.le;
        stk_req.wr_idx  = count_reg[IDX_W-1:0];
        stk_req.wr_data = '{tag: tag_reg, head: alu_rsp.res[ADDR_W-1:0], tail: tail_reg};
        // prefetch the newest entry while idle, then walk one entry per cycle
        stk_req.rd_idx  = (state_reg == ST_SEARCH) ? idx_m2[IDX_W-1:0]
                                                   : count_m1[IDX_W-1:0];
    end

    // register next values
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        end_next   = end_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        func_next  = func_reg;
        size_next  = size_reg;
        shift_next = shift_reg;
        down_next  = down_reg;
        tag_next   = tag_reg;
        baddr_next = baddr_reg;
        tmp_next   = tmp_reg;
        value_next = value_reg;
        ok_next    = ok_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    func_next  = func_t'(s_func);
                    size_next  = (s_alloc_size == '0) ? ADDR_W'(1) : s_alloc_size;
                    shift_next = s_align_shift;
                    down_next  = s_from_tail;
                    tag_next   = s_tag;
                    baddr_next = s_block_address;
                    idx_next   = count_reg;
                    value_next = '0;
                    ok_next    = 1'b0;
                    if (func_t'(s_func) == FUNC_FREE) begin
                        if (s_free_mode[0]) begin
                            head_next  = start_reg;
                            count_next = '0;
                        end
                        if (s_free_mode[1]) begin
                            tail_next  = end_reg;
                            count_next = '0;
                        end
                        ok_next = 1'b1;
                    end
                end
            end
            ST_STEP1: begin
                tmp_next = alu_rsp.res;
                case (func_reg)
                    FUNC_INIT: begin
                        if (!alu_rsp.neg) begin
                            head_next  = start_reg;
                            tail_next  = limit_reg;
                            end_next   = limit_reg;
                            count_next = '0;
                            ok_next    = 1'b1;
                        end
                    end
                    FUNC_ADJUST: begin
                        if (tail_reg == end_reg) begin
                            end_next   = head_reg;
                            tail_next  = head_reg;
                            value_next = alu_rsp.res[ADDR_W-1:0];
                            ok_next    = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_STEP2: begin
                case (func_reg)
                    FUNC_ALLOC: begin
                        if (down_reg) begin
                            if (!alu_rsp.neg) begin
                                tail_next  = tmp_reg[ADDR_W-1:0];
                                value_next = tmp_reg[ADDR_W-1:0];
                                ok_next    = 1'b1;
                            end
                        end else if (alu_rsp.le) begin
                            head_next  = alu_rsp.res[ADDR_W-1:0];
                            value_next = tmp_reg[ADDR_W-1:0];
                            ok_next    = 1'b1;
                        end
                    end
                    FUNC_RECORD: begin
                        if (alu_rsp.le) begin
                            head_next  = alu_rsp.res[ADDR_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                            value_next = tmp_reg[ADDR_W-1:0];
                            ok_next    = 1'b1;
                        end
                    end
                    FUNC_RESIZE: begin
                        if (alu_rsp.le) begin
                            head_next  = alu_rsp.res[ADDR_W-1:0];
                            value_next = size_reg;
                            ok_next    = 1'b1;
                        end
                    end
                    FUNC_QUERY: begin
                        ok_next = 1'b1;
                        if (!alu_rsp.neg && alu_rsp.res != '0) begin
                            value_next = alu_rsp.res[ADDR_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            ST_SEARCH: begin
                if (match) begin
                    head_next  = rd_data.head;
                    tail_next  = rd_data.tail;
                    count_next = idx_m1;
                    ok_next    = 1'b1;
                end else begin
                    idx_next = idx_m1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            start_reg <= '0;
            limit_reg <= '0;
            base_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            end_reg   <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            end_reg   <= end_next;
            count_reg <= count_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_REGION_START: start_reg <= cfg_wdata;
                    CFG_REGION_LIMIT: limit_reg <= cfg_wdata;
                    CFG_HEAP_BASE:    base_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        func_reg  <= func_next;
        size_reg  <= size_next;
        shift_reg <= shift_next;
        down_reg  <= down_next;
        tag_reg   <= tag_next;
        baddr_reg <= baddr_next;
        tmp_reg   <= tmp_next;
        value_reg <= value_next;
        ok_reg    <= ok_next;
    end

    assign res_valid = (state_reg == ST_DONE);
    assign res.value = value_reg;
    assign res.ok    = ok_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STATE_DEPTH))
        else $error("state stack count above depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_req.wr_en |-> (count_reg < CNT_W'(STATE_DEPTH)))
        else $error("push into full state stack");

    a_search_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (idx_reg != '0) && (idx_reg <= count_reg))
        else $error("search index out of range");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !res_ready) |=> (state_reg == ST_DONE) && $stable(value_reg))
        else $error("result dropped while output busy");

endmodule

[tb/tb.sv]
module tb;
    import dfa_pkg::*;

    typedef struct {
        func_t       func;
        logic [31:0] size;
        logic [3:0]  align_shift;
        logic        from_tail;
        logic [1:0]  free_mode;
        logic [31:0] tag;
        logic [31:0] block_address;
    } request_t;

    class frame_heap_model;
        logic [63:0] reg_start;
        logic [63:0] reg_limit;
        logic [63:0] reg_base;
        logic [63:0] head_ptr;
        logic [63:0] tail_ptr;
        logic [63:0] end_ptr;
        logic [31:0] saved_tag [STATE_DEPTH];
        logic [63:0] saved_head [STATE_DEPTH];
        logic [63:0] saved_tail [STATE_DEPTH];
        int unsigned saved_count;
        result_t     expected_q [$];
        int unsigned mismatches;

        function new();
            reg_start   = '0;
            reg_limit   = '0;
            reg_base    = '0;
            head_ptr    = '0;
            tail_ptr    = '0;
            end_ptr     = '0;
            saved_count = 0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_REGION_START: reg_start = {32'd0, data};
                CFG_REGION_LIMIT: reg_limit = {32'd0, data};
                CFG_HEAP_BASE:    reg_base  = {32'd0, data};
                default: ;
            endcase
        endfunction

        // aligned carve from head (upward) or tail (downward), no wrap
        function bit carve(logic [63:0] size, logic [63:0] align, bit down,
                           output logic [63:0] addr);
            logic [63:0] sz;
            logic [63:0] a;
            sz = (size == 0) ? 64'd1 : size;
            addr = '0;
            if (down) begin
                if (sz > tail_ptr) return 1'b0;
                a = (tail_ptr - sz) & ~(align - 64'd1);
                if (a < head_ptr) return 1'b0;
                tail_ptr = a;
            end else begin
                a = (head_ptr + align - 64'd1) & ~(align - 64'd1);
                if (a + sz > tail_ptr) return 1'b0;
                head_ptr = a + sz;
            end
            addr = a;
            return 1'b1;
        endfunction

        function void accept_request(request_t r);
            logic [63:0] sz;
            logic [63:0] align;
            logic [63:0] a;
            logic [63:0] block_end;
            result_t     res;
            int unsigned i;
            res.value = '0;
            res.ok    = 1'b0;
            sz    = {32'd0, r.size};
            align = 64'd1 << r.align_shift;
            case (r.func)
                FUNC_INIT: begin
                    if (reg_start <= reg_limit) begin
                        head_ptr    = reg_start;
                        tail_ptr    = reg_limit;
                        end_ptr     = reg_limit;
                        saved_count = 0;
                        res.ok      = 1'b1;
                    end
                end
                FUNC_ALLOC: begin
                    if (carve(sz, align, r.from_tail, a)) begin
                        res.value = a[31:0];
                        res.ok    = 1'b1;
                    end
                end
                FUNC_FREE: begin
                    if (r.free_mode[0]) begin
                        head_ptr    = reg_start;
                        saved_count = 0;
                    end
                    if (r.free_mode[1]) begin
                        tail_ptr    = end_ptr;
                        saved_count = 0;
                    end
                    res.ok = 1'b1;
                end
                FUNC_RECORD: begin
                    if (saved_count < STATE_DEPTH) begin
                        if (carve(64'(STATE_RECORD_BYTES), 64'(RECORD_ALIGN), 1'b0, a)) begin
                            saved_tag[saved_count]  = r.tag;
                            saved_head[saved_count] = head_ptr;
                            saved_tail[saved_count] = tail_ptr;
                            saved_count++;
                            res.value = a[31:0];
                            res.ok    = 1'b1;
                        end
                    end
                end
                FUNC_RESTORE: begin
                    i = saved_count;
                    while (i > 0 && r.tag != 0 && saved_tag[i-1] != r.tag) i--;
                    if (i > 0) begin
                        head_ptr    = saved_head[i-1];
                        tail_ptr    = saved_tail[i-1];
                        saved_count = i - 1;
                        res.ok      = 1'b1;
                    end
                end
                FUNC_RESIZE: begin
                    if (sz == 0) sz = 64'd1;
                    block_end = ({32'd0, r.block_address} + sz + 64'(RECORD_ALIGN) - 64'd1)
                                & ~(64'(RECORD_ALIGN) - 64'd1);
                    if (block_end <= tail_ptr) begin
                        head_ptr  = block_end;
                        res.value = sz[31:0];
                        res.ok    = 1'b1;
                    end
                end
                FUNC_ADJUST: begin
                    if (tail_ptr == end_ptr) begin
                        end_ptr   = head_ptr;
                        tail_ptr  = head_ptr;
                        res.value = head_ptr[31:0] - reg_base[31:0];
                        res.ok    = 1'b1;
                    end
                end
                default: begin
                    a = (head_ptr + align - 64'd1) & ~(align - 64'd1);
                    if (a < tail_ptr) res.value = 32'(tail_ptr - a);
                    res.ok = 1'b1;
                end
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [31:0] value, logic ok);
            result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual value %h ok %b",
                         $time, value, ok);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (value !== want.value) begin
                $display("%0t: value mismatch: expected %h, actual %h",
                         $time, want.value, value);
                mismatches++;
            end
            if (ok !== want.ok) begin
                $display("%0t: ok mismatch: expected %b, actual %b", $time, want.ok, ok);
                mismatches++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CFG_W-1:0]    cfg_addr;
    logic [ADDR_W-1:0]   cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [2:0]          s_func;
    logic [ADDR_W-1:0]   s_alloc_size;
    logic [3:0]          s_align_shift;
    logic                s_from_tail;
    logic [1:0]          s_free_mode;
    logic [ADDR_W-1:0]   s_tag;
    logic [ADDR_W-1:0]   s_block_address;
    logic                m_valid;
    logic                m_ready;
    logic [ADDR_W-1:0]   m_value;
    logic                m_ok;

    frame_heap_model fh = new();
    int unsigned     sender_quiet_left;
    int unsigned     record_burst;

    double_ended_frame_allocator u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_alloc_size    (s_alloc_size),
        .s_align_shift   (s_align_shift),
        .s_from_tail     (s_from_tail),
        .s_free_mode     (s_free_mode),
        .s_tag           (s_tag),
        .s_block_address (s_block_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value         (m_value),
        .m_ok            (m_ok)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic request_t make_req(func_t func, logic [31:0] size,
                                          logic [3:0] shift, logic from_tail,
                                          logic [1:0] mode, logic [31:0] tag,
                                          logic [31:0] baddr);
        request_t r;
        r.func          = func;
        r.size          = size;
        r.align_shift   = shift;
        r.from_tail     = from_tail;
        r.free_mode     = mode;
        r.tag           = tag;
        r.block_address = baddr;
        return r;
    endfunction

    function automatic request_t pick_request();
        request_t    r;
        int unsigned sel;
        logic [63:0] room;
        sel = $urandom_range(0, 99);
        room = fh.tail_ptr - fh.head_ptr;
        if (sel < 60)      r.size = $urandom_range(0, 48);
        else if (sel < 85) r.size = $urandom_range(0, 4096);
        else if (sel < 95) r.size = room[31:0] - $urandom_range(0, 3);
        else               r.size = $urandom();
        r.align_shift = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 4))
                                                   : 4'($urandom_range(0, 15));
        r.from_tail = 1'($urandom_range(0, 1));
        r.free_mode = 2'($urandom_range(0, 3));
        sel = $urandom_range(0, 99);
        if (sel < 70)      r.tag = $urandom_range(1, 4);
        else if (sel < 85) r.tag = 32'd0;
        else               r.tag = $urandom();
        sel = $urandom_range(0, 99);
        if (sel < 80) r.block_address = fh.head_ptr[31:0] - $urandom_range(0, 32);
        else          r.block_address = $urandom();
        // a run of records fills the state stack and hits the full case
        if (record_burst != 0) begin
            record_burst--;
            r.func = FUNC_RECORD;
            return r;
        end
        if ($urandom_range(0, 59) == 0) record_burst = STATE_DEPTH + 1;
        sel = $urandom_range(0, 99);
        if (sel < 4)       r.func = FUNC_INIT;
        else if (sel < 34) r.func = FUNC_ALLOC;
        else if (sel < 40) r.func = FUNC_FREE;
        else if (sel < 56) r.func = FUNC_RECORD;
        else if (sel < 68) r.func = FUNC_RESTORE;
        else if (sel < 76) r.func = FUNC_RESIZE;
        else if (sel < 80) r.func = FUNC_ADJUST;
        else               r.func = FUNC_QUERY;
        return r;
    endfunction

    task automatic send_request(input request_t r);
        int unsigned gap;
        if (sender_quiet_left != 0) begin
            gap = 0;
            sender_quiet_left--;
        end else begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 15) == 0) sender_quiet_left = $urandom_range(10, 40);
        end
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_func          <= r.func;
        s_alloc_size    <= r.size;
        s_align_shift   <= r.align_shift;
        s_from_tail     <= r.from_tail;
        s_free_mode     <= r.free_mode;
        s_tag           <= r.tag;
        s_block_address <= r.block_address;
        s_valid         <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        fh.accept_request(r);
    endtask

    // drop valid and hold until every result is back
    task automatic drain_requests();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (fh.expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_regs(logic [31:0] start, logic [31:0] limit, logic [31:0] base);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_REGION_START;
        cfg_wdata <= start;
        fh.write_reg(CFG_REGION_START, start);
        @(negedge aclk);
        cfg_addr  <= CFG_REGION_LIMIT;
        cfg_wdata <= limit;
        fh.write_reg(CFG_REGION_LIMIT, limit);
        @(negedge aclk);
        cfg_addr  <= CFG_HEAP_BASE;
        cfg_wdata <= base;
        fh.write_reg(CFG_HEAP_BASE, base);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_directed();
        send_request(make_req(FUNC_QUERY,   32'd0,        4'd0,  1'b0, 2'd0, 32'd0, 32'd0));
        send_request(make_req(FUNC_ALLOC,   32'd0,        4'd0,  1'b0, 2'd0, 32'd0, 32'd0));
        send_request(make_req(FUNC_ALLOC,   32'h10,       4'd12, 1'b0, 2'd0, 32'd0, 32'd0));
        send_request(make_req(FUNC_ALLOC,   32'h20,       4'd3,  1'b1, 2'd0, 32'd0, 32'd0));
        send_request(make_req(FUNC_ALLOC,   32'hFFFFFFFF, 4'd0,  1'b0, 2'd0, 32'd0, 32'd0));
        send_request(make_req(FUNC_ALLOC,   32'hFFFFFFFF, 4'd0,  1'b1, 2'd0, 32'd0, 32'd0));
        send_request(make_req(FUNC_QUERY,   32'd0,        4'd15, 1'b0, 2'd0, 32'd0, 32'd0));
        send_request(make_req(FUNC_RECORD,  32'd0,        4'd0,  1'b0, 2'd0, 32'd5, 32'd0));
        send_request(make_req(FUNC_RECORD,  32'd0,        4'd0,  1'b0, 2'd0, 32'd7, 32'd0));
        send_request(make_req(FUNC_RESTORE, 32'd0,        4'd0,  1'b0, 2'd0, 32'd99, 32'd0));
        send_request(make_req(FUNC_RESTORE, 32'd0,        4'd0,  1'b0, 2'd0, 32'd5, 32'd0));
        send_request(make_req(FUNC_RESTORE, 32'd0,        4'd0,  1'b0, 2'd0, 32'd0, 32'd0));
        send_request(make_req(FUNC_RESIZE,  32'd0,        4'd0,  1'b0, 2'd0, 32'd0, 32'h1000));
        send_request(make_req(FUNC_RESIZE,  32'hFFFFFFFF, 4'd0,  1'b0, 2'd0, 32'd0,
                              32'hFFFFFFFF));
        send_request(make_req(FUNC_ADJUST,  32'd0,        4'd0,  1'b0, 2'd0, 32'd0, 32'd0));
        send_request(make_req(FUNC_FREE,    32'd0,        4'd0,  1'b0, 2'd0, 32'd0, 32'd0));
        send_request(make_req(FUNC_FREE,    32'd0,        4'd0,  1'b0, 2'd2, 32'd0, 32'd0));
        send_request(make_req(FUNC_ADJUST,  32'd0,        4'd0,  1'b0, 2'd0, 32'd0, 32'd0));
        send_request(make_req(FUNC_FREE,    32'd0,        4'd0,  1'b0, 2'd3, 32'd0, 32'd0));
        send_request(make_req(FUNC_FREE,    32'd0,        4'd0,  1'b0, 2'd1, 32'd0, 32'd0));
        send_request(make_req(FUNC_ALLOC,   32'd1,        4'd12, 1'b1, 2'd0, 32'd0, 32'd0));
        send_request(make_req(FUNC_QUERY,   32'd0,        4'd2,  1'b0, 2'd0, 32'd0, 32'd0));
        send_request(make_req(FUNC_RECORD,  32'd0,        4'd0,  1'b0, 2'd0, 32'hFFFFFFFF,
                              32'd0));
        send_request(make_req(FUNC_RESTORE, 32'd0,        4'd0,  1'b0, 2'd0, 32'hFFFFFFFF,
                              32'd0));
    endtask

    initial begin
        logic [31:0] start;
        logic [31:0] limit;
        logic [31:0] base;
        aresetn           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_addr          = '0;
        cfg_wdata         = '0;
        s_valid           = 1'b0;
        s_func            = '0;
        s_alloc_size      = '0;
        s_align_shift     = '0;
        s_from_tail       = 1'b0;
        s_free_mode       = '0;
        s_tag             = '0;
        s_block_address   = '0;
        sender_quiet_left = 0;
        record_burst      = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin start = 32'h1000;     limit = 32'h2000;     base = 32'h800; end
                1: begin start = 32'h0;        limit = 32'h0;        base = 32'h0; end
                2: begin start = 32'h0;        limit = 32'hFFFFFFFF; base = 32'hFFFFFFFF; end
                3: begin start = 32'hFFFFFF00; limit = 32'hFFFFFFFF; base = 32'h12345678; end
                // start above limit: init is refused and the old state stays
                4: begin start = 32'h3000;     limit = 32'h2000;     base = $urandom(); end
                default: begin
                    start = $urandom_range(0, 32'hFFFF0000);
                    limit = start + $urandom_range(0, 32'h10000);
                    base  = $urandom();
                end
            endcase
            write_regs(start, limit, base);
            send_request(make_req(FUNC_INIT, 32'd0, 4'd0, 1'b0, 2'd0, 32'd0, 32'd0));
            if (p == 0) send_directed();
            for (int n = 0; n < 299; n++) send_request(pick_request());
            drain_requests();
        end
        repeat (24) @(posedge aclk);
        if (fh.mismatches == 0 && fh.expected_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        int unsigned stall;
        int unsigned quiet_left;
        int unsigned results_seen;
        quiet_left   = 0;
        results_seen = 0;
        m_ready      = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (quiet_left != 0) begin
                stall = 0;
                quiet_left--;
            end else begin
                stall = $urandom_range(0, 8);
                if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(10, 40);
            end
            // long hold-off so the block backs up and stalls its input
            if (results_seen == 450) stall = 300;
            @(negedge aclk);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            fh.check_result(m_value, m_ok);
            results_seen++;
        end
    end

    initial begin
        #5000000;
        $display("tb failed");
        $finish;
    end

endmodule
